/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on clk_i, with and without reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge of clk_i, quiet while rst_ni is low
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every rising edge of clk_i, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/smt_pkg.sv */
// ----------------------------------------------------------------------------
// Slice mapping table package
// Geometry, opcodes and the structs passed between the table modules.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int SlotsPerBlock = 128;
  localparam int BlockTotal    = 512;

  localparam int SlotAw    = 16;
  localparam int ValW      = 32;
  localparam int CntW      = 8;
  localparam int OffW      = $clog2(SlotsPerBlock);
  localparam int BlkW      = SlotAw - OffW;
  localparam int RowDepth  = (BlockTotal < (1 << BlkW)) ? BlockTotal : (1 << BlkW);
  localparam int SlotDepth = 1 << SlotAw;

  localparam logic [ValW-1:0] NoneMark = {ValW{1'b1}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_ERASE  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [CntW-1:0]          count;
    logic [SlotsPerBlock-1:0] valid;
  } smt_row_t;

  typedef struct packed {
    opcode_e           op;
    logic [SlotAw-1:0] slice;
    logic [ValW-1:0]   vsa;
  } smt_req_t;

  typedef struct packed {
    logic     row_we;
    smt_row_t row;
    logic     val_we;
  } smt_wb_t;

  typedef struct packed {
    logic [ValW-1:0] mapped;
    logic            was;
    logic [CntW-1:0] active;
  } smt_res_t;

endpackage

/* sv/slice_mapping_table_unit.sv */
// ----------------------------------------------------------------------------
// Slice mapping table unit
// Maps logical slices to virtual slices with insert, find and erase requests.
// A request is taken when start_i is high and busy_o low; its result beat
// shows on the result ports, marked by valid_o, after the op state and the
// result registers, for one cycle only, since the receiver cannot stall. No
// new request is taken before the write-back: the block row (valid marks and
// active count) and the slot value sit in memories with registered reads,
// read at the accept edge, modified and written back in the next cycle. After
// reset it clears all 512 block rows while busy, one block row per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slice_mapping_table_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  opcode_i,
  input  logic [smt_pkg::SlotAw-1:0]  logical_slice_i,
  input  logic [smt_pkg::ValW-1:0]    virtual_slice_i,
  output logic                        valid_o,
  output logic [smt_pkg::ValW-1:0]    mapped_slice_o,
  output logic                        slot_was_mapped_o,
  output logic [smt_pkg::CntW-1:0]    block_active_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_OP    = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [smt_pkg::BlkW-1:0]   clr_q, clr_d;
  logic                       valid_q;
  smt_pkg::smt_req_t          req_q;
  smt_pkg::smt_row_t          row_rd_q;
  logic [smt_pkg::ValW-1:0]   val_rd_q;
  smt_pkg::smt_res_t          res_q;
  smt_pkg::smt_wb_t           wb;
  smt_pkg::smt_res_t          res;
  logic                       accept;
  logic [smt_pkg::BlkW-1:0]   blk_in;
  logic [smt_pkg::BlkW-1:0]   blk_op;

  smt_pkg::smt_row_t          row_mem [smt_pkg::RowDepth];
  logic [smt_pkg::ValW-1:0]   val_mem [smt_pkg::SlotDepth];

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign blk_in = logical_slice_i[smt_pkg::SlotAw-1:smt_pkg::OffW];
  assign blk_op = req_q.slice[smt_pkg::SlotAw-1:smt_pkg::OffW];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = smt_pkg::BlkW'(clr_q + 1'b1);
        if (clr_q == smt_pkg::BlkW'(smt_pkg::RowDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_OP;
        end
      end
      ST_OP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= (state_q == ST_OP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.op    <= smt_pkg::opcode_e'(opcode_i);
      req_q.slice <= logical_slice_i;
      req_q.vsa   <= virtual_slice_i;
    end
    if (state_q == ST_OP) begin
      res_q <= res;
    end
  end

  // block rows: clearing pass, write-back, read at accept
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      row_mem[clr_q] <= '0;
    end else if (state_q == ST_OP && wb.row_we) begin
      row_mem[blk_op] <= wb.row;
    end
    if (accept) begin
      row_rd_q <= row_mem[blk_in];
    end
  end

  // slot values
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OP && wb.val_we) begin
      val_mem[req_q.slice] <= req_q.vsa;
    end
    if (accept) begin
      val_rd_q <= val_mem[logical_slice_i];
    end
  end

  smt_update u_update (
    .req_i   (req_q),
    .row_i   (row_rd_q),
    .value_i (val_rd_q),
    .wb_o    (wb),
    .res_o   (res)
  );

  assign valid_o           = valid_q;
  assign mapped_slice_o    = res_q.mapped;
  assign slot_was_mapped_o = res_q.was;
  assign block_active_o    = res_q.active;

  `ASSERT_CLK(a_beat_follows_op, (state_q == ST_OP) |=> valid_o, "no result beat after op")
  `ASSERT_CLK(a_beat_single, valid_o |=> !valid_o, "result beats back to back")
  `ASSERT_CLK(a_count_bound, valid_o |-> (int'(block_active_o) <= smt_pkg::SlotsPerBlock),
              "active count above slots per block")
  `ASSERT_CLK(a_mapped_counted,
              (valid_o && mapped_slice_o != smt_pkg::NoneMark) |-> (block_active_o != '0),
              "mapped slot in block with zero count")
  `ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !valid_o, "result beat during reset")

endmodule

/* sv/smt_update.sv */
// ----------------------------------------------------------------------------
// Slice mapping table update
// Modify step of the read-modify-write: new block row, value write enable
// and the result beat for one request.
// ----------------------------------------------------------------------------
module smt_update (
  input  smt_pkg::smt_req_t              req_i,
  input  smt_pkg::smt_row_t              row_i,
  input  logic [smt_pkg::ValW-1:0]       value_i,
  output smt_pkg::smt_wb_t               wb_o,
  output smt_pkg::smt_res_t              res_o
);

  logic [smt_pkg::OffW-1:0] off;
  logic [smt_pkg::BlkW-1:0] blk;
  logic                     in_range;
  logic                     was;
  logic                     do_map;
  logic                     do_unmap;
  logic                     now_valid;
  smt_pkg::smt_row_t        row_new;

  always_comb begin
    off      = req_i.slice[smt_pkg::OffW-1:0];
    blk      = req_i.slice[smt_pkg::SlotAw-1:smt_pkg::OffW];
    in_range = (int'(blk) < smt_pkg::BlockTotal);
    was      = row_i.valid[off];
    do_map   = 1'b0;
    do_unmap = 1'b0;
    unique case (req_i.op)
      smt_pkg::OP_INSERT: begin
        do_map   = (req_i.vsa != smt_pkg::NoneMark);
        do_unmap = (req_i.vsa == smt_pkg::NoneMark);
      end
      smt_pkg::OP_ERASE: begin
        do_unmap = 1'b1;
      end
      default: begin
        do_map   = 1'b0;
        do_unmap = 1'b0;
      end
    endcase

    row_new = row_i;
    if (do_map) begin
      row_new.valid[off] = 1'b1;
      if (!was) begin
        row_new.count = smt_pkg::CntW'(row_i.count + 1'b1);
      end
    end else if (do_unmap && was) begin
      row_new.valid[off] = 1'b0;
      if (row_i.count != '0) begin
        row_new.count = smt_pkg::CntW'(row_i.count - 1'b1);
      end
    end
    now_valid = row_new.valid[off];

    wb_o.row_we = in_range && (do_map || do_unmap);
    wb_o.row    = row_new;
    wb_o.val_we = in_range && do_map;

    if (!in_range) begin
      res_o.mapped = smt_pkg::NoneMark;
      res_o.was    = 1'b0;
      res_o.active = '0;
    end else begin
      res_o.mapped = do_map ? req_i.vsa : (now_valid ? value_i : smt_pkg::NoneMark);
      res_o.was    = was;
      res_o.active = row_new.count;
    end
  end

endmodule
